[rtl/dcbf_pkg.sv]
// dcbf_pkg: shared types and constants of the distance-cutoff bond finder
// no dependencies; imported by the interfaces, the top unit, dcbf_ctrl and dcbf_datapath
package dcbf_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned REG_W     = 34;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_W-1:0] MIN_DIST_RST   = REG_W'(41943);
  localparam logic [REG_W-1:0] SINGLE_MAX_RST = REG_W'(189399);
  localparam logic [REG_W-1:0] DOUBLE_MAX_RST = REG_W'(65536);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_DIST   = 2'd0,
    REG_SINGLE_MAX = 2'd1,
    REG_DOUBLE_MAX = 2'd2
  } reg_idx_e;

  localparam logic BOND_SINGLE = 1'b0;
  localparam logic BOND_DOUBLE = 1'b1;

  typedef struct packed {
    logic load;
    logic issue;
    logic last;
  } dcbf_cmd_t;

  typedef struct packed {
    logic stall;
    logic run_done;
  } dcbf_sts_t;

endpackage

[rtl/dcbf_if.sv]
// dcbf_in_if / dcbf_out_if: valid-ready channels for atom beats and bond beats
// depends on dcbf_pkg for field widths
interface dcbf_in_if import dcbf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      first_atom;
  logic signed [FIELD_W-1:0] coord_x;
  logic signed [FIELD_W-1:0] coord_y;
  logic signed [FIELD_W-1:0] coord_z;

  modport source (output valid, first_atom, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, first_atom, coord_x, coord_y, coord_z, output ready);
endinterface

interface dcbf_out_if import dcbf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] earlier_atom;
  logic [IDX_W-1:0] new_atom;
  logic             bond_kind;
  logic             last_of_run;

  modport source (output valid, earlier_atom, new_atom, bond_kind, last_of_run, input ready);
  modport sink   (input valid, earlier_atom, new_atom, bond_kind, last_of_run, output ready);
endinterface

[rtl/distance_cutoff_bond_finder_unit.sv]
// distance_cutoff_bond_finder_unit: an atom with n earlier atoms takes n store reads, one per
// cycle unless the bond sink stalls them, through three pipeline stages (store read, squared
// differences, sum and compare) and a flush that releases its last bond beat; a pair giving
// both bond kinds yields a single beat, then a double beat, and stalls the reads meanwhile; the
// next atom waits for the flush; with no earlier atom or a full store it may come next cycle
// reset clears control state and the atom count and loads default thresholds; store not cleared
module distance_cutoff_bond_finder_unit import dcbf_pkg::*; #(
  parameter int unsigned MAX_ATOMS  = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dcbf_in_if.sink              in_ch,
  dcbf_out_if.source           out_ch,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ATOMS);

  dcbf_cmd_t     cmd;
  dcbf_sts_t     sts;
  logic [AW-1:0] wr_addr, rd_addr;

  dcbf_ctrl #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_first_i (in_ch.first_atom),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  dcbf_datapath #(
    .MAX_ATOMS  (MAX_ATOMS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .coord_x_i     (in_ch.coord_x),
    .coord_y_i     (in_ch.coord_y),
    .coord_z_i     (in_ch.coord_z),
    .cmd_i         (cmd),
    .wr_addr_i     (wr_addr),
    .rd_addr_i     (rd_addr),
    .sts_o         (sts),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_earlier_o (out_ch.earlier_atom),
    .out_new_o     (out_ch.new_atom),
    .out_kind_o    (out_ch.bond_kind),
    .out_last_o    (out_ch.last_of_run)
  );

  a_done_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.run_done |=> in_ch.ready)
    else $error("controller not idle after drain");

  a_done_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.run_done |-> !in_ch.ready)
    else $error("drain finished while idle");

  a_no_read_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !cmd.issue)
    else $error("store read issued while idle");

endmodule

[rtl/dcbf_ram.sv]
// dcbf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module dcbf_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dcbf_ctrl.sv]
// dcbf_ctrl: controller that accepts atom beats, keeps the atom count and
// walks the stored atoms; depends on dcbf_pkg
module dcbf_ctrl import dcbf_pkg::*; #(
  parameter int unsigned MAX_ATOMS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_first_i,
  output logic                         in_ready_o,
  input  dcbf_sts_t                    sts_i,
  output dcbf_cmd_t                    cmd_o,
  output logic [$clog2(MAX_ATOMS)-1:0] wr_addr_o,
  output logic [$clog2(MAX_ATOMS)-1:0] rd_addr_o
);

  localparam int unsigned AW   = $clog2(MAX_ATOMS);
  localparam int unsigned CNTW = $clog2(MAX_ATOMS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WAIT} state_e;

  state_e          state_q;
  logic [CNTW-1:0] count_q;
  logic [AW-1:0]   j_q;
  logic [AW-1:0]   last_j_q;

  logic [CNTW-1:0] count_eff;
  logic            full;
  logic            accept;

  assign count_eff  = in_first_i ? '0 : count_q;
  assign full       = count_eff >= CNTW'(MAX_ATOMS);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign wr_addr_o  = count_eff[AW-1:0];
  assign rd_addr_o  = j_q;

  assign cmd_o.load  = accept && !full;
  assign cmd_o.issue = (state_q == ST_SCAN) && !sts_i.stall;
  assign cmd_o.last  = (j_q == last_j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      j_q      <= '0;
      last_j_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && !full) begin
            count_q  <= count_eff + CNTW'(1);
            j_q      <= '0;
            last_j_q <= count_eff[AW-1:0] - AW'(1);
            if (count_eff != '0) begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cmd_o.issue) begin
            if (cmd_o.last) begin
              state_q <= ST_WAIT;
            end else begin
              j_q <= j_q + AW'(1);
            end
          end
        end
        ST_WAIT: begin
          if (sts_i.run_done) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/dcbf_datapath.sv]
// dcbf_datapath: atom store, squared-distance pipeline, threshold registers
// and result staging; depends on dcbf_pkg and dcbf_ram
module dcbf_datapath import dcbf_pkg::*; #(
  parameter int unsigned MAX_ATOMS  = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [REG_IDX_W-1:0]         cfg_idx_i,
  input  logic [REG_W-1:0]             cfg_data_i,
  input  logic signed [FIELD_W-1:0]    coord_x_i,
  input  logic signed [FIELD_W-1:0]    coord_y_i,
  input  logic signed [FIELD_W-1:0]    coord_z_i,
  input  dcbf_cmd_t                    cmd_i,
  input  logic [$clog2(MAX_ATOMS)-1:0] wr_addr_i,
  input  logic [$clog2(MAX_ATOMS)-1:0] rd_addr_i,
  output dcbf_sts_t                    sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [IDX_W-1:0]             out_earlier_o,
  output logic [IDX_W-1:0]             out_new_o,
  output logic                         out_kind_o,
  output logic                         out_last_o
);

  localparam int unsigned AW   = $clog2(MAX_ATOMS);
  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned SQW  = 2 * CW;
  localparam int unsigned D2W  = SQW + 2;
  localparam int unsigned CMPW = (D2W > REG_W) ? D2W : REG_W;

  // threshold registers
  logic [REG_W-1:0] min_q, sgl_q, dbl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_DIST_RST;
      sgl_q <= SINGLE_MAX_RST;
      dbl_q <= DOUBLE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_DIST:   min_q <= cfg_data_i;
        REG_SINGLE_MAX: sgl_q <= cfg_data_i;
        REG_DOUBLE_MAX: dbl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // current atom
  logic [CW-1:0] in_x, in_y, in_z;
  logic [CW-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic [AW-1:0] new_idx_q;

  assign in_x = CW'($unsigned(coord_x_i));
  assign in_y = CW'($unsigned(coord_y_i));
  assign in_z = CW'($unsigned(coord_z_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q   <= in_x;
      cur_y_q   <= in_y;
      cur_z_q   <= in_z;
      new_idx_q <= wr_addr_i;
    end
  end

  // stall signal and atom store
  logic adv;
  logic [3*CW-1:0] rd_data;

  dcbf_ram #(
    .WIDTH (3 * CW),
    .DEPTH (MAX_ATOMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (wr_addr_i),
    .wdata_i ({in_x, in_y, in_z}),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  // stage 1: store read
  logic          s1_v_q, s1_end_q;
  logic [AW-1:0] s1_j_q;

  // stage 2: squared differences
  logic signed [CW:0]      dx, dy, dz;
  logic signed [2*CW+1:0]  px, py, pz;
  logic [SQW-1:0]          sqx_q, sqy_q, sqz_q;
  logic                    s2_v_q, s2_end_q;
  logic [AW-1:0]           s2_j_q;

  assign dx = $signed({cur_x_q[CW-1], cur_x_q})
            - $signed({rd_data[3*CW-1], rd_data[3*CW-1:2*CW]});
  assign dy = $signed({cur_y_q[CW-1], cur_y_q})
            - $signed({rd_data[2*CW-1], rd_data[2*CW-1:CW]});
  assign dz = $signed({cur_z_q[CW-1], cur_z_q})
            - $signed({rd_data[CW-1], rd_data[CW-1:0]});
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // stage 3: sum and threshold compare
  logic [CMPW-1:0] d2;
  logic            s3_v_q, s3_end_q, s3_sgl_q, s3_dbl_q;
  logic [AW-1:0]   s3_j_q;

  assign d2 = CMPW'(sqx_q) + CMPW'(sqy_q) + CMPW'(sqz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_j_q   <= rd_addr_i;
      s1_end_q <= cmd_i.last;
      s2_j_q   <= s1_j_q;
      s2_end_q <= s1_end_q;
      sqx_q    <= px[SQW-1:0];
      sqy_q    <= py[SQW-1:0];
      sqz_q    <= pz[SQW-1:0];
      s3_j_q   <= s2_j_q;
      s3_end_q <= s2_end_q;
      s3_sgl_q <= (d2 > CMPW'(min_q)) && (d2 < CMPW'(sgl_q));
      s3_dbl_q <= (d2 > CMPW'(min_q)) && (d2 < CMPW'(dbl_q));
    end
  end

  // result staging: one held result, released once the next one or the end is known
  logic             sub_q, flush_q;
  logic             hold_v_q, hold_kind_q;
  logic [IDX_W-1:0] hold_j_q;
  logic             out_v_q, out_kind_q, out_last_q;
  logic [IDX_W-1:0] out_earlier_q, out_new_q;

  logic out_free, want_sgl, want_dbl, has_res, push, s3_take, flush_go, hold_to_out;
  logic res_kind;

  assign out_free    = !out_v_q || out_ready_i;
  assign want_sgl    = s3_v_q && s3_sgl_q && !sub_q;
  assign want_dbl    = s3_v_q && s3_dbl_q;
  assign has_res     = want_sgl || want_dbl;
  assign res_kind    = want_sgl ? BOND_SINGLE : BOND_DOUBLE;
  assign push        = has_res && (!hold_v_q || out_free);
  assign s3_take     = s3_v_q && (!has_res || (push && !(want_sgl && s3_dbl_q)));
  assign adv         = !(s3_v_q && !s3_take);
  assign flush_go    = flush_q && (!hold_v_q || out_free);
  assign hold_to_out = hold_v_q && (push || flush_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q    <= 1'b0;
      flush_q  <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (push && want_sgl && s3_dbl_q) begin
        sub_q <= 1'b1;
      end else if (s3_take) begin
        sub_q <= 1'b0;
      end

      if (s3_take && s3_end_q) begin
        flush_q <= 1'b1;
      end else if (flush_go) begin
        flush_q <= 1'b0;
      end

      if (push) begin
        hold_v_q <= 1'b1;
      end else if (flush_go) begin
        hold_v_q <= 1'b0;
      end

      if (hold_to_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      hold_j_q    <= IDX_W'(s3_j_q);
      hold_kind_q <= res_kind;
    end
    if (hold_to_out) begin
      out_earlier_q <= hold_j_q;
      out_new_q     <= IDX_W'(new_idx_q);
      out_kind_q    <= hold_kind_q;
      out_last_q    <= flush_go;
    end
  end

  assign sts_o.stall    = !adv;
  assign sts_o.run_done = flush_go;

  assign out_valid_o   = out_v_q;
  assign out_earlier_o = out_earlier_q;
  assign out_new_o     = out_new_q;
  assign out_kind_o    = out_kind_q;
  assign out_last_o    = out_last_q;

endmodule
